[design/hsv_to_rgb_converter_unit_assert.svh]
// Assertion macros used by the checker file.
`ifndef HSV_TO_RGB_CONVERTER_UNIT_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define HSVRGB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsv_to_rgb assertion failed");

// Next-cycle implication, disabled while in reset.
`define HSVRGB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsv_to_rgb assertion failed");

`endif

[design/hsvrgb_pkg.sv]
`default_nettype none

package hsvrgb_pkg;

    localparam int unsigned ChanW   = 8;
    localparam int unsigned HueW    = 16;
    localparam int unsigned FracW   = 16;
    localparam int unsigned TermW   = 24;
    localparam int unsigned QuotW   = 16;

    // 255 * 65536, the common denominator of the b and c terms
    localparam logic [TermW-1:0] Den      = 24'd16711680;
    localparam logic [FracW:0]   FracOne  = 17'h10000;
    localparam logic [ChanW-1:0] Full     = 8'd255;
    // ceil(2^23 / 255): exact floor(x / 255) for any 16-bit x
    localparam logic [15:0]      Recip255 = 16'd32897;

    // Color sector of the hue circle
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

    // After stage 1: sector split
    typedef struct packed {
        sector_t            sector;
        logic [ChanW-1:0]   v;
        logic [ChanW-1:0]   s;
        logic [FracW-1:0]   f;
    } split_t;

    // After stage 2: saturation terms
    typedef struct packed {
        sector_t            sector;
        logic [ChanW-1:0]   v;
        logic [TermW-1:0]   tb;
        logic [TermW-1:0]   tc;
        logic [QuotW-1:0]   pa;
    } terms_t;

    // After stage 3: brightness products, b and c divided by 65536
    typedef struct packed {
        sector_t            sector;
        logic [ChanW-1:0]   v;
        logic [QuotW-1:0]   qa;
        logic [QuotW-1:0]   qb;
        logic [QuotW-1:0]   qc;
    } quot_t;

    // After stage 4: final channel candidates
    typedef struct packed {
        sector_t            sector;
        logic [ChanW-1:0]   v;
        logic [ChanW-1:0]   a;
        logic [ChanW-1:0]   b;
        logic [ChanW-1:0]   c;
    } chan_t;

    // floor(x / 255) by reciprocal multiply; valid for x <= 65025
    function automatic logic [ChanW-1:0] div255(input logic [QuotW-1:0] x);
        logic [31:0] p;
        p = {16'd0, x} * {16'd0, Recip255};
        return p[30:23];
    endfunction

endpackage

`default_nettype wire

[design/hsvrgb_if.sv]
`default_nettype none

// HSV input channel
interface hsvrgb_hsv_if;
    logic        valid;
    logic        ready;
    logic [15:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

// RGB output channel
interface hsvrgb_rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

[design/hsvrgb_front.sv]
`default_nettype none

// Stages 1 and 2: hue sector split, then saturation products
module hsvrgb_front
    import hsvrgb_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    hsvrgb_hsv_if.sink  hsv,
    output terms_t      terms,
    output logic        terms_valid,
    input  wire logic   terms_ready
);

    logic       s1_valid_reg;
    split_t     s1_reg;
    logic       s2_valid_reg;
    terms_t     s2_reg;
    logic       s1_ready;
    logic       s2_ready;
    logic [18:0]    h6;
    split_t     s1_next;
    terms_t     s2_next;
    logic [FracW:0] fc;
    logic [23:0]    sf;
    logic [24:0]    sfc;

    // Stage readiness: a stage takes data when empty or draining
    assign s2_ready = !s2_valid_reg || terms_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign hsv.ready = s1_ready;

    // Stage 1: hue * 6 split into sector and fraction
    always_comb
    begin
        h6 = {1'b0, hsv.hue, 2'b00} + {2'b00, hsv.hue, 1'b0};
        s1_next.sector = sector_t'(h6[18:16]);
        s1_next.f      = h6[15:0];
        s1_next.v      = hsv.brightness;
        s1_next.s      = hsv.saturation;
    end

    // Stage 2: Den - S*f, Den - S*(1-f) and V*(255-S)
    always_comb
    begin
        fc  = FracOne - {1'b0, s1_reg.f};
        sf  = {16'd0, s1_reg.s} * {8'd0, s1_reg.f};
        sfc = {17'd0, s1_reg.s} * {8'd0, fc};
        s2_next.sector = s1_reg.sector;
        s2_next.v      = s1_reg.v;
        s2_next.tb     = Den - sf;
        s2_next.tc     = Den - sfc[23:0];
        s2_next.pa     = {8'd0, s1_reg.v} * {8'd0, Full - s1_reg.s};
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= hsv.valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (s1_ready && hsv.valid)
            s1_reg <= s1_next;
        if (s2_ready && s1_valid_reg)
            s2_reg <= s2_next;
    end

    assign terms       = s2_reg;
    assign terms_valid = s2_valid_reg;

endmodule

`default_nettype wire

[design/hsvrgb_scale.sv]
`default_nettype none

// Stages 3 and 4: brightness products, then exact divide by 255
module hsvrgb_scale
    import hsvrgb_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire terms_t terms,
    input  wire logic   terms_valid,
    output logic        terms_ready,
    output chan_t       chans,
    output logic        chans_valid,
    input  wire logic   chans_ready
);

    logic   s3_valid_reg;
    quot_t  s3_reg;
    logic   s4_valid_reg;
    chan_t  s4_reg;
    logic   s3_ready;
    logic   s4_ready;
    quot_t  s3_next;
    chan_t  s4_next;
    logic [31:0] pb;
    logic [31:0] pc;

    assign s4_ready    = !s4_valid_reg || chans_ready;
    assign s3_ready    = !s3_valid_reg || s4_ready;
    assign terms_ready = s3_ready;

    // Stage 3: V times each term, dropping the 2^16 part of the denominator
    always_comb
    begin
        pb = {24'd0, terms.v} * {8'd0, terms.tb};
        pc = {24'd0, terms.v} * {8'd0, terms.tc};
        s3_next.sector = terms.sector;
        s3_next.v      = terms.v;
        s3_next.qa     = terms.pa;
        s3_next.qb     = pb[31:16];
        s3_next.qc     = pc[31:16];
    end

    // Stage 4: remaining divide by 255
    always_comb
    begin
        s4_next.sector = s3_reg.sector;
        s4_next.v      = s3_reg.v;
        s4_next.a      = div255(s3_reg.qa);
        s4_next.b      = div255(s3_reg.qb);
        s4_next.c      = div255(s3_reg.qc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_ready)
                s3_valid_reg <= terms_valid;
            if (s4_ready)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && terms_valid)
            s3_reg <= s3_next;
        if (s4_ready && s3_valid_reg)
            s4_reg <= s4_next;
    end

    assign chans       = s4_reg;
    assign chans_valid = s4_valid_reg;

endmodule

`default_nettype wire

[design/hsvrgb_route.sv]
`default_nettype none

// Stage 5: sector routing into the output register
module hsvrgb_route
    import hsvrgb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire chan_t    chans,
    input  wire logic     chans_valid,
    output logic          chans_ready,
    hsvrgb_rgb_if.source  rgb
);

    logic             out_valid_reg;
    logic [ChanW-1:0] red_reg;
    logic [ChanW-1:0] green_reg;
    logic [ChanW-1:0] blue_reg;
    logic [ChanW-1:0] red_next;
    logic [ChanW-1:0] green_next;
    logic [ChanW-1:0] blue_next;

    assign chans_ready = !out_valid_reg || rgb.ready;

    // Channel select per sector
    always_comb
    begin
        unique case (chans.sector)
            SEC_RED_YEL:
            begin
                red_next = chans.v; green_next = chans.c; blue_next = chans.a;
            end
            SEC_YEL_GRN:
            begin
                red_next = chans.b; green_next = chans.v; blue_next = chans.a;
            end
            SEC_GRN_CYN:
            begin
                red_next = chans.a; green_next = chans.v; blue_next = chans.c;
            end
            SEC_CYN_BLU:
            begin
                red_next = chans.a; green_next = chans.b; blue_next = chans.v;
            end
            SEC_BLU_MAG:
            begin
                red_next = chans.c; green_next = chans.a; blue_next = chans.v;
            end
            default:
            begin
                red_next = chans.v; green_next = chans.a; blue_next = chans.b;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (chans_ready)
            out_valid_reg <= chans_valid;
    end

    always_ff @(posedge clk)
    begin
        if (chans_ready && chans_valid)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign rgb.valid = out_valid_reg;
    assign rgb.red   = red_reg;
    assign rgb.green = green_reg;
    assign rgb.blue  = blue_reg;

endmodule

`default_nettype wire

[design/hsv_to_rgb_converter_unit.sv]
// Channel | Dir | Payload                              | Handshake
// hsv     | in  | hue[15:0] saturation[7:0] brightness[7:0] | valid/ready
// rgb     | out | red[7:0] green[7:0] blue[7:0]        | valid/ready
//
// One transaction per cycle sustained while rgb is ready. The register stages
// are sector split, saturation products, brightness products, divide by 255
// and sector routing. Each stage loads when empty or draining, so bubbles
// close up and the input stays ready while any stage is free. A stall on rgb
// holds each full stage with no free stage after it. Reset clears the valid bits only.
`default_nettype none

module hsv_to_rgb_converter_unit
    import hsvrgb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    hsvrgb_hsv_if.sink    hsv,
    hsvrgb_rgb_if.source  rgb
);

    terms_t terms;
    logic   terms_valid;
    logic   terms_ready;
    chan_t  chans;
    logic   chans_valid;
    logic   chans_ready;

    hsvrgb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .hsv         (hsv),
        .terms       (terms),
        .terms_valid (terms_valid),
        .terms_ready (terms_ready)
    );

    hsvrgb_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .terms       (terms),
        .terms_valid (terms_valid),
        .terms_ready (terms_ready),
        .chans       (chans),
        .chans_valid (chans_valid),
        .chans_ready (chans_ready)
    );

    hsvrgb_route u_route (
        .clk         (clk),
        .rst_n       (rst_n),
        .chans       (chans),
        .chans_valid (chans_valid),
        .chans_ready (chans_ready),
        .rgb         (rgb)
    );

endmodule

`default_nettype wire

[design/hsvrgb_checker.sv]
`default_nettype none
`include "hsv_to_rgb_converter_unit_assert.svh"

// Port-level checks for the converter
module hsvrgb_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       hsv_valid,
    input wire logic       hsv_ready,
    input wire logic       rgb_valid,
    input wire logic       rgb_ready,
    input wire logic [7:0] red,
    input wire logic [7:0] green,
    input wire logic [7:0] blue
);

    logic [2:0]  inflight_reg;
    logic [2:0]  inflight_next;
    logic [23:0] color_bits;

    // Whole output payload, for the hold check
    assign color_bits = {red, green, blue};

    // Transactions inside the pipeline
    always_comb
    begin
        inflight_next = inflight_reg;
        if (hsv_valid && hsv_ready)
            inflight_next = inflight_next + 3'd1;
        if (rgb_valid && rgb_ready)
            inflight_next = inflight_next - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= 3'd0;
        else
            inflight_reg <= inflight_next;
    end

    `HSVRGB_ASSERT_NXT(a_rgb_valid_hold, clk, rst_n, rgb_valid && !rgb_ready, rgb_valid)
    `HSVRGB_ASSERT_NXT(a_rgb_data_hold, clk, rst_n, rgb_valid && !rgb_ready, $stable(color_bits))
    `HSVRGB_ASSERT_IMP(a_ready_when_out_empty, clk, rst_n, !rgb_valid, hsv_ready)
    `HSVRGB_ASSERT_IMP(a_no_invented_result, clk, rst_n, rgb_valid, inflight_reg != 3'd0)

endmodule

bind hsv_to_rgb_converter_unit hsvrgb_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .hsv_valid (hsv.valid),
    .hsv_ready (hsv.ready),
    .rgb_valid (rgb.valid),
    .rgb_ready (rgb.ready),
    .red       (rgb.red),
    .green     (rgb.green),
    .blue      (rgb.blue)
);

`default_nettype wire
